@@ hw/rtl/bmp_pixel_stream_to_rgb565_assert.svh @@
// assertion macros for the bmp pixel stream converter rtl
// no dependencies; empty bodies when SYNTHESIS is defined
`ifndef BMP_PIXEL_STREAM_TO_RGB565_ASSERT_SVH
`define BMP_PIXEL_STREAM_TO_RGB565_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define BMPC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define BMPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BMPC_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define BMPC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ hw/rtl/bmpc_pkg.sv @@
// shared constants, widths and types of the bmp pixel stream converter
// no dependencies
package bmpc_pkg;

    localparam int LINES_PER_BATCH = 8;
    localparam int MAX_WIDTH       = 4096;

    localparam int BPP_W   = 3;
    localparam int WREG_W  = 13;
    localparam int CFG_W   = 13;
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int EFFW_W  = COL_W + 1;
    localparam int LINE_W  = (LINES_PER_BATCH > 1) ? $clog2(LINES_PER_BATCH) : 1;

    typedef logic [BPP_W-1:0]  bpp_t;
    typedef logic [WREG_W-1:0] wreg_t;
    typedef logic [CFG_W-1:0]  cfg_data_t;
    typedef logic [COL_W-1:0]  col_t;
    typedef logic [EFFW_W-1:0] effw_t;
    typedef logic [LINE_W-1:0] line_t;

    typedef enum logic [1:0] {
        CFG_BYTES_PER_PIXEL = 2'd0,
        CFG_RGB555_SOURCE   = 2'd1,
        CFG_IMAGE_WIDTH     = 2'd2
    } cfg_index_t;

    // control from the top level to the pixel gatherer
    typedef struct packed {
        logic step;
        bpp_t bpp;
        logic rgb555;
    } gather_ctl_t;

    // status from the pixel gatherer
    typedef struct packed {
        logic pixel_done;
        logic mid_pixel;
    } gather_stat_t;

endpackage

@@ hw/rtl/bmpc_pixel_gather.sv @@
// gathers pixel bytes and converts finished pixels to rgb565
// depends on bmpc_pkg
module bmpc_pixel_gather (
    input  logic                   clk,
    input  logic                   rst_n,
    input  bmpc_pkg::gather_ctl_t  ctl,
    input  logic [7:0]             data_byte,
    output bmpc_pkg::gather_stat_t stat,
    output logic [15:0]            color
);

    logic [1:0]  byte_position_reg;
    logic [1:0]  byte_position_next;
    logic [15:0] held_bytes_reg;
    logic [15:0] held_bytes_next;
    logic        done;

    // pixel completes once the byte index reaches size minus one
    assign done = ({1'b0, byte_position_reg} + 3'd1) >= ctl.bpp;

    assign stat.pixel_done = done;
    assign stat.mid_pixel  = (byte_position_reg != 2'd0);

    always_comb
    begin
        case (ctl.bpp)
            3'd2:
            begin
                if (ctl.rgb555)
                    color = {data_byte[6:0], held_bytes_reg[7:5], 1'b0, held_bytes_reg[4:0]};
                else
                    color = {data_byte, held_bytes_reg[7:0]};
            end
            3'd3:    color = {data_byte[7:3], held_bytes_reg[15:10], held_bytes_reg[7:3]};
            default: color = held_bytes_reg;
        endcase
    end

    always_comb
    begin
        byte_position_next = byte_position_reg;
        held_bytes_next    = held_bytes_reg;
        if (ctl.step)
        begin
            if (done)
            begin
                byte_position_next = 2'd0;
                held_bytes_next    = 16'd0;
            end
            else
            begin
                byte_position_next = byte_position_reg + 2'd1;
                case (byte_position_reg)
                    2'd0:    held_bytes_next = {8'd0, data_byte};
                    2'd1:    held_bytes_next = {data_byte, held_bytes_reg[7:0]};
                    // red of a 4-byte pixel: fold to rgb565, alpha still to come
                    default: held_bytes_next = {data_byte[7:3], held_bytes_reg[15:10],
                                                held_bytes_reg[7:3]};
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg <= 2'd0;
            held_bytes_reg    <= 16'd0;
        end
        else
        begin
            byte_position_reg <= byte_position_next;
            held_bytes_reg    <= held_bytes_next;
        end
    end

endmodule

@@ hw/rtl/bmp_pixel_stream_to_rgb565.sv @@
// top level of the bmp pixel-data byte stream to rgb565 converter
// depends on bmpc_pkg, bmpc_pixel_gather and bmp_pixel_stream_to_rgb565_assert.svh
//
//   channel  dir  handshake         payload
//   in       in   in_valid/in_stall data_byte[7:0]
//   out      out  out_valid/out_stall pixel_rgb565[15:0], line_end, batch_end
//   cfg      in   cfg_write         cfg_index[1:0], cfg_data[12:0]
//
// one byte per cycle sustained while out_stall is low; a byte passes through the
// byte register, then the result register
// padding bytes and non-final pixel bytes give no item on the output
// reset (async, active low) clears all counters, the gatherer and valid flags
// out_stall reaches in_stall only while the byte register is full and the
// result register is held
`include "bmp_pixel_stream_to_rgb565_assert.svh"

module bmp_pixel_stream_to_rgb565 (
    input  logic        clk,
    input  logic        rst_n,
    // input byte channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] pixel_rgb565,
    output logic        line_end,
    output logic        batch_end,
    // configuration write port
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data
);

    // configuration registers
    bmpc_pkg::bpp_t  bytes_per_pixel_reg;
    logic            rgb555_source_reg;
    bmpc_pkg::wreg_t image_width_reg;

    // byte register
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;

    // row and batch bookkeeping
    bmpc_pkg::col_t  pixel_column_reg;
    bmpc_pkg::col_t  pixel_column_next;
    logic [1:0]      padding_left_reg;
    logic [1:0]      padding_left_next;
    bmpc_pkg::line_t line_in_batch_reg;
    bmpc_pkg::line_t line_in_batch_next;

    // result register
    logic        out_valid_reg;
    logic [15:0] pixel_rgb565_reg;
    logic        line_end_reg;
    logic        batch_end_reg;

    // effective settings after clamping
    bmpc_pkg::bpp_t  eff_bpp;
    bmpc_pkg::effw_t eff_width;

    logic                   out_free;
    logic                   s1_move;
    logic                   skip_byte;
    logic                   row_done;
    logic                   batch_done;
    logic [1:0]             pad_prod;
    logic [15:0]            color;
    bmpc_pkg::gather_ctl_t  gctl;
    bmpc_pkg::gather_stat_t gstat;

    // clamp pixel size to 2..4
    always_comb
    begin
        if (bytes_per_pixel_reg < 3'd2)
            eff_bpp = 3'd2;
        else if (bytes_per_pixel_reg > 3'd4)
            eff_bpp = 3'd4;
        else
            eff_bpp = bytes_per_pixel_reg;
    end

    // clamp width to 1..max
    always_comb
    begin
        if (image_width_reg == '0)
            eff_width = bmpc_pkg::effw_t'(1);
        else if (int'(image_width_reg) > bmpc_pkg::MAX_WIDTH)
            eff_width = bmpc_pkg::effw_t'(bmpc_pkg::MAX_WIDTH);
        else
            eff_width = bmpc_pkg::effw_t'(image_width_reg);
    end

    // handshake: result register frees when empty or taken
    assign out_free  = !out_valid_reg || !out_stall;
    assign s1_move   = s1_valid_reg && out_free;
    assign in_stall  = s1_valid_reg && !out_free;
    assign skip_byte = (padding_left_reg != 2'd0);

    assign gctl.step   = s1_move && !skip_byte;
    assign gctl.bpp    = eff_bpp;
    assign gctl.rgb555 = rgb555_source_reg;

    bmpc_pixel_gather u_gather (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (gctl),
        .data_byte (s1_byte_reg),
        .stat      (gstat),
        .color     (color)
    );

    assign row_done   = (int'(pixel_column_reg) + 1) >= int'(eff_width);
    assign batch_done = (int'(line_in_batch_reg) + 1) >= bmpc_pkg::LINES_PER_BATCH;

    // row bytes mod 4 only depends on the low two bits of width and size
    assign pad_prod = 2'(eff_width[1:0] * eff_bpp[1:0]);

    always_comb
    begin
        pixel_column_next  = pixel_column_reg;
        padding_left_next  = padding_left_reg;
        line_in_batch_next = line_in_batch_reg;
        if (s1_move && skip_byte)
        begin
            padding_left_next = padding_left_reg - 2'd1;
        end
        else if (gctl.step && gstat.pixel_done)
        begin
            if (row_done)
            begin
                pixel_column_next = '0;
                padding_left_next = 2'd0 - pad_prod;
                if (batch_done)
                    line_in_batch_next = '0;
                else
                    line_in_batch_next = line_in_batch_reg + bmpc_pkg::line_t'(1);
            end
            else
            begin
                pixel_column_next = pixel_column_reg + bmpc_pkg::col_t'(1);
            end
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_per_pixel_reg <= 3'd2;
            rgb555_source_reg   <= 1'b0;
            image_width_reg     <= bmpc_pkg::wreg_t'(1);
        end
        else if (cfg_write)
        begin
            case (bmpc_pkg::cfg_index_t'(cfg_index))
                bmpc_pkg::CFG_BYTES_PER_PIXEL: bytes_per_pixel_reg <= cfg_data[2:0];
                bmpc_pkg::CFG_RGB555_SOURCE:   rgb555_source_reg   <= cfg_data[0];
                bmpc_pkg::CFG_IMAGE_WIDTH:     image_width_reg     <= cfg_data;
                default:                       ;
            endcase
        end
    end

    // byte register, counters and valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            pixel_column_reg  <= '0;
            padding_left_reg  <= 2'd0;
            line_in_batch_reg <= '0;
        end
        else
        begin
            if (!in_stall)
                s1_valid_reg <= in_valid;
            if (out_free)
                out_valid_reg <= gctl.step && gstat.pixel_done;
            pixel_column_reg  <= pixel_column_next;
            padding_left_reg  <= padding_left_next;
            line_in_batch_reg <= line_in_batch_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (!in_stall)
            s1_byte_reg <= data_byte;
        if (out_free)
        begin
            pixel_rgb565_reg <= color;
            line_end_reg     <= row_done;
            batch_end_reg    <= row_done && batch_done;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pixel_rgb565 = pixel_rgb565_reg;
    assign line_end     = line_end_reg;
    assign batch_end    = batch_end_reg;

    // a batch only ends on the last pixel of a row
    `BMPC_ASSERT_IMPLY(a_batch_on_line, clk, rst_n, out_valid_reg && batch_end_reg, line_end_reg)
    // padding is only skipped between pixels
    `BMPC_ASSERT_IMPLY(a_pad_between, clk, rst_n, padding_left_reg != 2'd0, !gstat.mid_pixel)
    // line counter wraps before the batch size
    `BMPC_ASSERT_IMPLY(a_line_range, clk, rst_n, 1'b1,
        int'(line_in_batch_reg) < bmpc_pkg::LINES_PER_BATCH)
    // a held result is not replaced
    `BMPC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid_reg && out_stall, out_valid_reg)

endmodule

@@ tb/tb_top.sv @@
// self-checking testbench for bmp_pixel_stream_to_rgb565: byte stream in, rgb565 pixels out
// depends on bmpc_pkg and the converter rtl; holds its own pixel predictor in a scoreboard
// class and drives the block through directed corners, a clamped-width stretch and random rows
module tb_top;

    // one expected or observed output item
    typedef struct packed {
        logic [15:0] rgb;
        logic        line_last;
        logic        batch_last;
    } pixel_t;

    // predictor of the converter plus the queue of pixels still owed by the block
    class pixel_scoreboard;
        bmpc_pkg::bpp_t  bpp_reg;
        logic            rgb555_reg;
        bmpc_pkg::wreg_t width_reg;
        logic [1:0]      byte_idx;
        logic [15:0]     gathered;
        bmpc_pkg::col_t  column;
        logic [1:0]      pad_left;
        bmpc_pkg::line_t rows_done;
        pixel_t          owed_pixels[$];
        int              errors;

        function new();
            bpp_reg    = 3'd2;
            rgb555_reg = 1'b0;
            width_reg  = 13'd1;
            byte_idx   = '0;
            gathered   = '0;
            column     = '0;
            pad_left   = '0;
            rows_done  = '0;
            errors     = 0;
        endfunction

        function void set_reg(bmpc_pkg::cfg_index_t idx, int unsigned value);
            case (idx)
                bmpc_pkg::CFG_BYTES_PER_PIXEL: bpp_reg    = value[bmpc_pkg::BPP_W-1:0];
                bmpc_pkg::CFG_RGB555_SOURCE:   rgb555_reg = value[0];
                bmpc_pkg::CFG_IMAGE_WIDTH:     width_reg  = value[bmpc_pkg::WREG_W-1:0];
                default: ;
            endcase
        endfunction

        // truncate 8-bit red, green, blue to 5-6-5
        function logic [15:0] to_rgb565(logic [7:0] r, logic [7:0] g, logic [7:0] b);
            return {r[7:3], g[7:2], b[7:3]};
        endfunction

        function int pending();
            return owed_pixels.size();
        endfunction

        // accepted input byte: advance the predictor, queue a pixel if one completes
        function void take_byte(logic [7:0] b);
            int unsigned n_bpp;
            int unsigned n_width;
            int unsigned pos;
            pixel_t      px;
            n_bpp   = (bpp_reg < 2) ? 2 : (bpp_reg > 4) ? 4 : bpp_reg;
            n_width = (width_reg == 0) ? 1 :
                      (width_reg > bmpc_pkg::MAX_WIDTH) ? bmpc_pkg::MAX_WIDTH : width_reg;
            pos     = byte_idx;
            if (pad_left != 0)
            begin
                pad_left = pad_left - 2'd1;
                return;
            end
            if (pos + 1 < n_bpp)
            begin
                case (pos)
                    0: gathered = {8'h00, b};
                    1: gathered = {b, gathered[7:0]};
                    default: gathered = to_rgb565(b, gathered[15:8], gathered[7:0]);
                endcase
                byte_idx = 2'(pos + 1);
                return;
            end
            if (n_bpp == 2)
                px.rgb = rgb555_reg ? {b[6:0], gathered[7:5], 1'b0, gathered[4:0]}
                                    : {b, gathered[7:0]};
            else if (n_bpp == 3)
                px.rgb = to_rgb565(b, gathered[15:8], gathered[7:0]);
            else
                px.rgb = gathered;
            byte_idx      = '0;
            gathered      = '0;
            px.line_last  = 1'b0;
            px.batch_last = 1'b0;
            if (column + 1 >= n_width)
            begin
                px.line_last = 1'b1;
                column       = '0;
                pad_left     = 2'((4 - ((n_width * n_bpp) & 3)) & 3);
                if (rows_done + 1 >= bmpc_pkg::LINES_PER_BATCH)
                begin
                    px.batch_last = 1'b1;
                    rows_done     = '0;
                end
                else
                    rows_done = rows_done + 1'b1;
            end
            else
                column = column + 1'b1;
            owed_pixels.push_back(px);
        endfunction

        function void check_pixel(logic [15:0] rgb, logic line_last, logic batch_last);
            pixel_t want;
            if (owed_pixels.size() == 0)
            begin
                $error("unexpected pixel %h line_end %0b batch_end %0b", rgb, line_last,
                       batch_last);
                errors++;
                return;
            end
            want = owed_pixels.pop_front();
            if (rgb !== want.rgb)
            begin
                $error("pixel_rgb565 expected %h actual %h", want.rgb, rgb);
                errors++;
            end
            if (line_last !== want.line_last)
            begin
                $error("line_end expected %0b actual %0b", want.line_last, line_last);
                errors++;
            end
            if (batch_last !== want.batch_last)
            begin
                $error("batch_end expected %0b actual %0b", want.batch_last, batch_last);
                errors++;
            end
        endfunction
    endclass

    // generous watchdog, far beyond the slowest legal run
    localparam int CYCLE_LIMIT = 400000;
    // the random byte budget
    localparam int RANDOM_BYTES = 920;
    // back-to-back bytes sent under the clamped width
    localparam int WIDE_BYTES = 256;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [15:0] pixel_rgb565;
    logic        line_end;
    logic        batch_end;
    logic        cfg_write = 1'b0;
    logic [1:0]  cfg_index = 2'd0;
    logic [12:0] cfg_data  = 13'd0;

    // when set, neither side idles: gives long back-to-back stretches
    logic        quiet = 1'b0;
    int          cycle_count = 0;

    pixel_scoreboard sb = new();

    // directed corners, grouped by the setting each group runs under:
    //   0..7   reset setting (2-byte 565, width 1): two rows, two padding bytes each
    //   8..11  pixel size 0 acting as 2, rgb555, width 0 acting as 1
    //   12..19 3-byte bgr, width 2: one row of 6 bytes plus 2 padding bytes
    //   20..23 pixel size 7 acting as 4, width 1: bgra, alpha dropped, no padding
    logic [7:0] corner_bytes [24] = '{
        8'h00, 8'hFF, 8'hAB, 8'hCD,
        8'hFF, 8'h00, 8'h11, 8'h22,
        8'hFF, 8'h7F, 8'h00, 8'h80,
        8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h55, 8'hAA,
        8'hFF, 8'h00, 8'hFF, 8'h80
    };

    bmp_pixel_stream_to_rgb565 uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pixel_rgb565 (pixel_rgb565),
        .line_end     (line_end),
        .batch_end    (batch_end),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // receiver: random stall with a 9 percent chance, none while quiet
    always @(posedge clk)
        out_stall <= !quiet && ($urandom_range(0, 99) < 9);

    // output monitor: values seen here are the ones from before this edge
    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            sb.check_pixel(pixel_rgb565, line_end, batch_end);

    // offer one byte, with a random one-cycle idle gap first, and wait for it to be taken
    task automatic send_byte(logic [7:0] b);
        if (!quiet && $urandom_range(0, 99) < 9)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        do
            @(posedge clk);
        while (in_stall);
        sb.take_byte(b);
    endtask

    // stop sending, let every owed pixel arrive, then let the byte pipeline empty
    // (padding and partial-pixel bytes give no item)
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
        repeat (4) @(posedge clk);
    endtask

    // write all three registers back to back; only called while the block is idle
    task automatic program_cfg(int unsigned bpp, int unsigned rgb555, int unsigned width);
        cfg_write <= 1'b1;
        cfg_index <= bmpc_pkg::CFG_BYTES_PER_PIXEL;
        cfg_data  <= 13'(bpp);
        @(posedge clk);
        sb.set_reg(bmpc_pkg::CFG_BYTES_PER_PIXEL, bpp);
        cfg_index <= bmpc_pkg::CFG_RGB555_SOURCE;
        cfg_data  <= 13'(rgb555);
        @(posedge clk);
        sb.set_reg(bmpc_pkg::CFG_RGB555_SOURCE, rgb555);
        cfg_index <= bmpc_pkg::CFG_IMAGE_WIDTH;
        cfg_data  <= 13'(width);
        @(posedge clk);
        sb.set_reg(bmpc_pkg::CFG_IMAGE_WIDTH, width);
        cfg_write <= 1'b0;
    endtask

    initial
    begin
        int sent;
        int unsigned bpp;
        int unsigned width;
        int unsigned n_bpp;
        int unsigned n_width;
        int unsigned row_bytes;
        int unsigned n_bytes;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners, first group under the reset setting
        for (int i = 0; i < 24; i++)
        begin
            if (i == 8)
            begin
                drain();
                program_cfg(0, 1, 0);
            end
            else if (i == 12)
            begin
                drain();
                program_cfg(3, 0, 2);
            end
            else if (i == 20)
            begin
                drain();
                program_cfg(7, 0, 1);
            end
            send_byte(corner_bytes[i]);
        end

        // width register at its top value, clamped to the widest row; a long stretch
        // of 2-byte pixels back to back with no idling, leaving the row open
        drain();
        quiet = 1'b1;
        program_cfg(2, 0, 8191);
        for (int i = 0; i < WIDE_BYTES; i++)
            send_byte(8'($urandom_range(0, 255)));
        drain();
        quiet = 1'b0;

        // random phases: mostly whole rows so the row and batch counters get exercised,
        // some with a stray tail so the next setting lands mid-pixel or mid-padding
        sent = 0;
        while (sent < RANDOM_BYTES)
        begin
            bpp = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) : $urandom_range(2, 4);
            case ($urandom_range(0, 9))
                0:       width = 0;
                1:       width = $urandom_range(13, 60);
                default: width = $urandom_range(1, 12);
            endcase
            n_bpp     = (bpp < 2) ? 2 : (bpp > 4) ? 4 : bpp;
            n_width   = (width == 0) ? 1 : width;
            row_bytes = n_width * n_bpp;
            row_bytes = row_bytes + ((4 - (row_bytes & 3)) & 3);
            n_bytes   = row_bytes * $urandom_range(1, 10);
            if ($urandom_range(0, 3) == 0)
                n_bytes = n_bytes + $urandom_range(1, 7);

            drain();
            quiet = ($urandom_range(0, 5) == 0);
            program_cfg(bpp, $urandom_range(0, 1), width);
            for (int i = 0; i < n_bytes && sent < RANDOM_BYTES; i++)
            begin
                send_byte(8'($urandom_range(0, 255)));
                sent = sent + 1;
            end
        end

        // wait for the last owed pixels, then keep watching for anything stray
        quiet = 1'b0;
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
        repeat (8) @(posedge clk);

        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ bmp_pixel_stream_to_rgb565.f @@
+incdir+hw/rtl
hw/rtl/bmpc_pkg.sv
hw/rtl/bmpc_pixel_gather.sv
hw/rtl/bmp_pixel_stream_to_rgb565.sv
tb/tb_top.sv
